// ----- sv/gse_pkg.sv -----
// Shared types and constants of the gray-level Sobel edge stream.
package gse_pkg;

	// Field and datapath widths.
	localparam int PIX_W   = 8;
	localparam int COORD_W = 11;
	localparam int SIZE_W  = 12;
	localparam int GRAD_W  = 11;
	localparam int LINE_W  = 2 * PIX_W;

	// Frame size limits and reset values.
	localparam logic [SIZE_W-1:0] SIZE_MIN    = 12'd3;
	localparam logic [SIZE_W-1:0] HEIGHT_MAX  = 12'd2048;
	localparam logic [SIZE_W-1:0] WIDTH_RST   = 12'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RST  = 12'd480;
	localparam int                COL_LIMIT   = 2048;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_IDX_WIDTH  = 1'b0;
	localparam logic REG_IDX_HEIGHT = 1'b1;

	// Saturation level of the edge magnitude.
	localparam logic [PIX_W-1:0] EDGE_MAX = 8'd255;

	// Position of one item in the frame and the flags derived from it.
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               valid;
		logic               inner;
		logic               last;
	} pos_t;

endpackage

// ----- sv/gse_pos.sv -----
// Raster position tracker: clamps the frame size and counts rows and columns.
module gse_pos import gse_pkg::*; #(
	parameter int MAX_COLS = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SIZE_W-1:0] frame_width,
	input  logic [SIZE_W-1:0] frame_height,
	input  logic              frame_start,
	input  logic              adv,
	output pos_t              pos
);

	localparam logic [SIZE_W-1:0] WIDTH_MAX = SIZE_W'(MAX_COLS);

	logic [COORD_W-1:0] col_q, row_q;
	logic [SIZE_W-1:0]  sz_w, sz_h;
	logic [SIZE_W-1:0]  c0, r0, c1, r1, cn, rn;
	logic [SIZE_W-1:0]  col_d, row_d;

	// Clamp the configured frame size to the supported range.
	always_comb begin
		if (frame_width < SIZE_MIN) begin
			sz_w = SIZE_MIN;
		end else if (frame_width > WIDTH_MAX) begin
			sz_w = WIDTH_MAX;
		end else begin
			sz_w = frame_width;
		end
		if (frame_height < SIZE_MIN) begin
			sz_h = SIZE_MIN;
		end else if (frame_height > HEIGHT_MAX) begin
			sz_h = HEIGHT_MAX;
		end else begin
			sz_h = frame_height;
		end
	end

	// Position of the current item, wrapping anything past the frame edges.
	always_comb begin
		c0 = frame_start ? '0 : {1'b0, col_q};
		r0 = frame_start ? '0 : {1'b0, row_q};
		if (c0 >= sz_w) begin
			c1 = '0;
			r1 = r0 + 12'd1;
		end else begin
			c1 = c0;
			r1 = r0;
		end
		if (r1 >= sz_h) begin
			r1 = '0;
		end
		pos.row   = r1[COORD_W-1:0];
		pos.col   = c1[COORD_W-1:0];
		pos.valid = (r1 != '0) && (c1 != '0);
		pos.inner = (r1 >= 12'd2) && (c1 >= 12'd2);
		pos.last  = (r1 == sz_h - 12'd1) && (c1 == sz_w - 12'd1);
	end

	// Position of the following item.
	always_comb begin
		cn = c1 + 12'd1;
		rn = r1 + 12'd1;
		if (cn >= sz_w) begin
			col_d = '0;
			row_d = (rn >= sz_h) ? '0 : rn;
		end else begin
			col_d = cn;
			row_d = r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (adv) begin
			col_q <= col_d[COORD_W-1:0];
			row_q <= row_d[COORD_W-1:0];
		end
	end

endmodule

// ----- sv/gse_line_mem.sv -----
// Line store memory holding the two previous rows per column, with write forwarding.
module gse_line_mem import gse_pkg::*; #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [LINE_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [LINE_W-1:0] wr_data
);

	logic [LINE_W-1:0] ram [DEPTH];
	logic [LINE_W-1:0] ram_q;
	logic [LINE_W-1:0] fwd_q;
	logic              hit_q;

	// Single write port; the read data register only loads on a read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ram[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q <= ram[rd_addr];
			fwd_q <= wr_data;
		end
	end

	// A write to the same entry in the cycle of the read supersedes the stale read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd_en) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = hit_q ? fwd_q : ram_q;

endmodule

// ----- sv/gse_grad.sv -----
// Sliding 3x3 window columns and the Sobel gradient stage.
module gse_grad import gse_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [PIX_W-1:0]         top_pix,
	input  logic [PIX_W-1:0]         mid_pix,
	input  logic [PIX_W-1:0]         bot_pix,
	output logic signed [GRAD_W-1:0] gx_s2,
	output logic signed [GRAD_W-1:0] gy_s2
);

	// Columns c-2 (entries 0..2) and c-1 (entries 3..5), top to bottom.
	logic [PIX_W-1:0] win_q [6];
	logic [9:0] right_sum, left_sum, bot_sum, top_sum;
	logic signed [GRAD_W-1:0] gx, gy;

	// Weighted sums of the four window edges.
	always_comb begin
		right_sum = 10'(top_pix) + {1'b0, mid_pix, 1'b0} + 10'(bot_pix);
		left_sum  = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
		bot_sum   = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(bot_pix);
		top_sum   = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(top_pix);
		gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
		gy = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
	end

	// Shift the window by one column per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_pix;
			win_q[4] <= mid_pix;
			win_q[5] <= bot_pix;
		end
	end

	// Gradient pipeline register.
	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s2 <= gx;
			gy_s2 <= gy;
		end
	end

endmodule

// ----- sv/gray_sobel_edge_stream.sv -----
// Top level of the gray-level Sobel edge stream: registers, pipeline control and output stage.
//
// The block takes one pixel per clock while in_stall is low and gives one result per pixel,
// in order. The pipeline is three registers deep, from the accepted pixel to the output
// register: gray conversion and line store read, window and gradients, then magnitude
// and output. The line stores are one memory of 16-bit entries (row r-2 above row r-1)
// that every pixel reads and writes once, at its column; a write to the column being read
// in the same cycle is forwarded, so consecutive pixels at the same column cost nothing.
// The memory gets no clearing pass after reset: the first two rows of a frame never use
// what it held, so each frame should open with frame_start. A stalled output holds its
// result while the two stages behind it still fill, so up to two further pixels are taken
// before in_stall rises.
module gray_sobel_edge_stream import gse_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// Pixel input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PIX_W-1:0]   chan0,
	input  logic [PIX_W-1:0]   chan1,
	input  logic [PIX_W-1:0]   chan2,
	input  logic               frame_start,
	// Result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic [PIX_W-1:0]   edge_res,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_col,
	output logic               out_valid,
	output logic               frame_last
);

	localparam int LINE_DEPTH = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [SIZE_W-1:0] frame_width_q, frame_height_q;
	logic              cfg_wr;

	logic        in_fire, s1_en, s2_en, out_en, s1_fire;
	logic        s1_v, s2_v, res_valid_q;
	pos_t        pos, pos_s1, pos_s2;
	logic [11:0] gray_sum;
	logic [PIX_W-1:0]  gray, gray_s1;
	logic [LINE_W-1:0] line_rd;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;
	logic [9:0]  abs_x, abs_y;
	logic [10:0] mag;
	logic [PIX_W-1:0]  edge_d;

	logic [PIX_W-1:0]   edge_res_q;
	logic [COORD_W-1:0] out_row_q, out_col_q;
	logic               out_valid_q, frame_last_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RST;
			frame_height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IDX_WIDTH: frame_width_q <= pwdata[SIZE_W-1:0];
				REG_IDX_HEIGHT: frame_height_q <= pwdata[SIZE_W-1:0];
				default: frame_height_q <= frame_height_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_IDX_WIDTH: prdata = {(PDATA_W - SIZE_W)'(0), frame_width_q};
			REG_IDX_HEIGHT: prdata = {(PDATA_W - SIZE_W)'(0), frame_height_q};
			default: prdata = '0;
		endcase
	end

	// Pipeline flow: each stage moves when it is empty or the stage after it moves.
	assign out_en   = !res_valid_q || !res_stall;
	assign s2_en    = !s2_v || out_en;
	assign s1_en    = !s1_v || s2_en;
	assign in_stall = !s1_en;
	assign in_fire  = in_valid && s1_en;
	assign s1_fire  = s1_v && s2_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v        <= 1'b0;
			s2_v        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_v <= in_valid;
			end
			if (s2_en) begin
				s2_v <= s1_v;
			end
			if (out_en) begin
				res_valid_q <= s2_v;
			end
		end
	end

	// Position of the incoming item.
	gse_pos #(
		.MAX_COLS(LINE_DEPTH)
	) u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.frame_start (frame_start),
		.adv         (in_fire),
		.pos         (pos)
	);

	// Gray level: (4*c0 + 10*c1 + 2*c2) / 16.
	assign gray_sum = (12'(chan0) << 2) + (12'(chan1) << 3) + (12'(chan1) << 1)
	                + (12'(chan2) << 1);
	assign gray = gray_sum[11:4];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_s1  <= pos;
			gray_s1 <= gray;
		end
		if (s1_fire) begin
			pos_s2 <= pos_s1;
		end
	end

	// Line store: read at accept, written back as the item leaves the first stage.
	gse_line_mem #(
		.DEPTH (LINE_DEPTH),
		.ADDR_W(ADDR_W)
	) u_line_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_fire),
		.rd_addr(pos.col[ADDR_W-1:0]),
		.rd_data(line_rd),
		.wr_en  (s1_fire),
		.wr_addr(pos_s1.col[ADDR_W-1:0]),
		.wr_data({line_rd[PIX_W-1:0], gray_s1})
	);

	// Window and gradients.
	gse_grad u_grad (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (s1_fire),
		.top_pix(line_rd[LINE_W-1:PIX_W]),
		.mid_pix(line_rd[PIX_W-1:0]),
		.bot_pix(gray_s1),
		.gx_s2  (gx_s2),
		.gy_s2  (gy_s2)
	);

	// L1 magnitude, saturated, and zero on the frame border.
	always_comb begin
		abs_x = gx_s2[GRAD_W-1] ? 10'(-gx_s2) : gx_s2[9:0];
		abs_y = gy_s2[GRAD_W-1] ? 10'(-gy_s2) : gy_s2[9:0];
		mag   = 11'(abs_x) + 11'(abs_y);
		if (!pos_s2.inner) begin
			edge_d = '0;
		end else if (mag > 11'(EDGE_MAX)) begin
			edge_d = EDGE_MAX;
		end else begin
			edge_d = mag[PIX_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (out_en && s2_v) begin
			edge_res_q   <= edge_d;
			out_row_q    <= pos_s2.valid ? pos_s2.row - 11'd1 : '0;
			out_col_q    <= pos_s2.valid ? pos_s2.col - 11'd1 : '0;
			out_valid_q  <= pos_s2.valid;
			frame_last_q <= pos_s2.last;
		end
	end

	assign res_valid  = res_valid_q;
	assign edge_res   = edge_res_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_valid  = out_valid_q;
	assign frame_last = frame_last_q;

`ifndef SYNTHESIS
	// The input only stalls when the first stage is occupied.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_v)
		else $error("input stalled with an empty first stage");

	// An accepted item occupies the first stage on the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> s1_v)
		else $error("accepted item lost before the first stage");

	// A result without a center carries zero fields.
	a_missing_center_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !out_valid) |-> (edge_res == '0 && out_row == '0 && out_col == '0))
		else $error("missing center with nonzero result fields");

	// A nonzero edge never lies on the top row or left column.
	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && edge_res != '0) |-> (out_row != '0 && out_col != '0))
		else $error("nonzero edge on the frame border");
`endif

endmodule

// ----- test/gray_sobel_edge_stream_tb.sv -----
// Self-checking testbench for the gray-level Sobel edge stream.
`timescale 1ns / 100ps

module gray_sobel_edge_stream_tb;
	import gse_pkg::*;

	localparam int MAX_COLS      = 2048;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int WIDE_ITEMS    = 200;
	localparam int TALL_ROWS     = 40;
	localparam int FILL_COLS     = 40;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam int HOLD_CYCLES   = 60;
	localparam int TAIL_CYCLES   = 8;

	// Pixel content styles and idling levels.
	typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH, PIX_MIXED} pix_style_t;
	typedef enum {IDLE_NONE, IDLE_SHORT, IDLE_FULL} idle_level_t;

	// One expected result item.
	typedef struct {
		logic [PIX_W-1:0]   edge_val;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               valid;
		logic               last;
	} edge_result_t;

	// Block inputs, all known from time zero.
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               psel        = 1'b0;
	logic               penable     = 1'b0;
	logic               pwrite      = 1'b0;
	logic [PADDR_W-1:0] paddr       = '0;
	logic [PDATA_W-1:0] pwdata      = '0;
	logic               in_valid    = 1'b0;
	logic [PIX_W-1:0]   chan0       = '0;
	logic [PIX_W-1:0]   chan1       = '0;
	logic [PIX_W-1:0]   chan2       = '0;
	logic               frame_start = 1'b0;
	logic               res_stall   = 1'b0;

	// Block outputs.
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_stall;
	logic               res_valid;
	logic [PIX_W-1:0]   edge_res;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic               out_valid;
	logic               frame_last;

	// Shared testbench state.
	edge_result_t expected_edges[$];
	idle_level_t  idle_level   = IDLE_NONE;
	int           hold_request = 0;
	int           hold_left    = 0;
	int           fail_cnt     = 0;
	int           cycle_cnt    = 0;
	bit           offering     = 1'b0;

	// Predictor state: registers, line stores, window and position.
	logic [SIZE_W-1:0] cfg_width  = WIDTH_RST;
	logic [SIZE_W-1:0] cfg_height = HEIGHT_RST;
	logic [PIX_W-1:0]  upper_line[MAX_COLS] = '{default: '0};
	logic [PIX_W-1:0]  lower_line[MAX_COLS] = '{default: '0};
	logic [PIX_W-1:0]  win_col[6] = '{default: '0};
	int                col_pos = 0;
	int                row_pos = 0;

	gray_sobel_edge_stream #(
		.MAX_WIDTH(MAX_COLS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.chan0      (chan0),
		.chan1      (chan1),
		.chan2      (chan2),
		.frame_start(frame_start),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.edge_res   (edge_res),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_valid  (out_valid),
		.frame_last (frame_last)
	);

	always #2 clk = ~clk;

	// Cycle counter with a hard limit on the run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Frame sizes are used clamped to the legal range.
	function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int hi);
		int s;
		s = int'(v);
		if (s < int'(SIZE_MIN))
			s = int'(SIZE_MIN);
		else if (s > hi)
			s = hi;
		return s;
	endfunction

	// Works out the result of one accepted pixel and advances the predictor state.
	function automatic edge_result_t predict_edge(input logic [PIX_W-1:0] c0, c1, c2,
		input logic fs);
		edge_result_t       res;
		int                 w, h, r, c, gx, gy, mag;
		logic [PIX_W-1:0]   gray, top, mid;
		logic [COORD_W-1:0] ci;
		w = clamp_size(cfg_width, MAX_COLS);
		h = clamp_size(cfg_height, int'(HEIGHT_MAX));
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		// A position left past the frame by a size change wraps first.
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		r = row_pos;
		c = col_pos;
		ci = COORD_W'(c);

		gray = PIX_W'((4 * int'(c0) + 10 * int'(c1) + 2 * int'(c2)) >> 4);
		top = upper_line[ci];
		mid = lower_line[ci];
		upper_line[ci] = mid;
		lower_line[ci] = gray;

		// Only inner centers get a gradient; border centers stay at zero.
		res.edge_val = '0;
		if (r >= 2 && c >= 2) begin
			gx = (int'(top) + 2 * int'(mid) + int'(gray))
				- (int'(win_col[0]) + 2 * int'(win_col[1]) + int'(win_col[2]));
			gy = (int'(win_col[2]) + 2 * int'(win_col[5]) + int'(gray))
				- (int'(win_col[0]) + 2 * int'(win_col[3]) + int'(top));
			mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			res.edge_val = (mag > int'(EDGE_MAX)) ? EDGE_MAX : PIX_W'(mag);
		end

		win_col[0] = win_col[3];
		win_col[1] = win_col[4];
		win_col[2] = win_col[5];
		win_col[3] = top;
		win_col[4] = mid;
		win_col[5] = gray;

		res.valid = (r >= 1 && c >= 1);
		res.row   = res.valid ? COORD_W'(r - 1) : '0;
		res.col   = res.valid ? COORD_W'(c - 1) : '0;
		res.last  = (r == h - 1 && c == w - 1);

		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
		return res;
	endfunction

	// Counts and reports a mismatch.
	task automatic check_field(input string field_name, input logic [31:0] expv, actv);
		if (actv !== expv) begin
			fail_cnt++;
			$error("%s: expected %0d, got %0d", field_name, expv, actv);
		end
	endtask

	// Compares each accepted result item with the oldest expectation.
	always @(posedge clk) begin : result_check
		edge_result_t exp_res;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_edges.size() == 0) begin
				fail_cnt++;
				$error("result item with no expectation pending");
			end else begin
				exp_res = expected_edges.pop_front();
				check_field("edge_res", exp_res.edge_val, edge_res);
				check_field("out_row", exp_res.row, out_row);
				check_field("out_col", exp_res.col, out_col);
				check_field("out_valid", exp_res.valid, out_valid);
				check_field("frame_last", exp_res.last, frame_last);
			end
		end
	end

	// Receiver stalls: random short stalls, rare long ones, and requested hold-offs.
	always @(posedge clk) begin : stall_gen
		int r;
		r = $urandom_range(0, 99);
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else if (idle_level == IDLE_NONE) begin
			res_stall <= 1'b0;
		end else if (idle_level == IDLE_FULL && r < 2) begin
			hold_left = $urandom_range(8, 30);
			res_stall <= 1'b1;
		end else begin
			res_stall <= (r < 25);
		end
	end

	// Gap before the next item: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (idle_level == IDLE_NONE || r < 60)
			return 0;
		if (idle_level == IDLE_SHORT || r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [PIX_W-1:0] pick_chan(input pix_style_t style);
		case (style)
			PIX_UNIFORM: return PIX_W'($urandom_range(0, 255));
			PIX_EXTREME: return $urandom_range(0, 1) ? EDGE_MAX : '0;
			PIX_SMOOTH:  return PIX_W'($urandom_range(100, 140));
			default:     return ($urandom_range(0, 3) == 0) ? EDGE_MAX :
				PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Offers one pixel item and records its expected result once it is accepted.
	task automatic send_pixel(input logic [PIX_W-1:0] c0, c1, c2, input logic fs);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			if (offering) begin
				in_valid <= 1'b0;
				offering = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		offering    = 1'b1;
		chan0       <= c0;
		chan1       <= c1;
		chan2       <= c2;
		frame_start <= fs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_edges.push_back(predict_edge(c0, c1, c2, fs));
	endtask

	task automatic send_random(input pix_style_t style, input logic fs);
		send_pixel(pick_chan(style), pick_chan(style), pick_chan(style), fs);
	endtask

	// Stops offering items and waits until every expected result has come.
	task automatic drain_results();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		do
			@(posedge clk);
		while (expected_edges.size() != 0);
	endtask

	// One register access: setup cycle, then access cycle until pready.
	task automatic reg_access(input logic reg_idx, input logic wr,
		input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= PADDR_W'({reg_idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (wr) begin
			if (reg_idx == REG_IDX_WIDTH)
				cfg_width = wdata[SIZE_W-1:0];
			else
				cfg_height = wdata[SIZE_W-1:0];
		end
	endtask

	task automatic check_register(input logic reg_idx, input string field_name,
		input logic [SIZE_W-1:0] expv);
		logic [PDATA_W-1:0] rdata;
		reg_access(reg_idx, 1'b0, '0, rdata);
		check_field(field_name, expv, rdata[SIZE_W-1:0]);
	endtask

	// Writes both frame size registers once the block is idle, then reads them back.
	// Upper data bits carry random noise that the registers must drop.
	task automatic set_frame_size(input logic [SIZE_W-1:0] wval, hval);
		logic [PDATA_W-1:0] wdata, rdata;
		drain_results();
		wdata = $urandom;
		wdata[SIZE_W-1:0] = wval;
		reg_access(REG_IDX_WIDTH, 1'b1, wdata, rdata);
		wdata = $urandom;
		wdata[SIZE_W-1:0] = hval;
		reg_access(REG_IDX_HEIGHT, 1'b1, wdata, rdata);
		check_register(REG_IDX_WIDTH, "frame_width", wval);
		check_register(REG_IDX_HEIGHT, "frame_height", hval);
	endtask

	// Registers read back their reset sizes.
	task automatic test_reset_values();
		check_register(REG_IDX_WIDTH, "frame_width", WIDTH_RST);
		check_register(REG_IDX_HEIGHT, "frame_height", HEIGHT_RST);
	endtask

	// Smallest frames: saturation, channel extremes, an abandoned frame and the
	// automatic wrap after a frame's last pixel.
	task automatic test_directed();
		logic [PIX_W-1:0] v;
		set_frame_size(12'd3, 12'd3);
		idle_level = IDLE_FULL;
		// Dark left columns against a bright right column saturate the center.
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				v = (c == 2) ? EDGE_MAX : '0;
				send_pixel(v, v, v, r == 0 && c == 0);
			end
		end
		// A frame cut short by the next frame start: one channel at full scale each, then all three.
		send_pixel(EDGE_MAX, '0, '0, 1'b1);
		send_pixel('0, EDGE_MAX, '0, 1'b0);
		send_pixel('0, '0, EDGE_MAX, 1'b0);
		send_pixel(EDGE_MAX, EDGE_MAX, EDGE_MAX, 1'b0);
		// A ramp over rows and columns; its gradient is still large enough to saturate.
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				v = PIX_W'(40 * r + 7 * c);
				send_pixel(v, v, v, r == 0 && c == 0);
			end
		end
		// No frame start: the position has wrapped to the frame origin by itself.
		for (int i = 0; i < 3; i++)
			send_random(PIX_UNIFORM, 1'b0);
		drain_results();
	endtask

	// The receiver holds off long enough for the block to fill and stall its input.
	task automatic test_output_hold();
		set_frame_size(12'd6, 12'd5);
		idle_level = IDLE_NONE;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 30; i++)
			send_random(PIX_UNIFORM, i == 0);
		drain_results();
	endtask

	// The start of the widest and the tallest frames, reached through out-of-range
	// register values, then a whole frame that fills every line store entry that the
	// random frames can reach.
	task automatic test_size_extremes();
		set_frame_size(12'hFFF, 12'd0);
		idle_level = IDLE_SHORT;
		for (int i = 0; i < WIDE_ITEMS; i++)
			send_random(PIX_MIXED, i == 0);
		set_frame_size(12'd2, 12'hFFF);
		for (int i = 0; i < 3 * TALL_ROWS; i++)
			send_random(PIX_MIXED, i == 0);
		set_frame_size(SIZE_W'(FILL_COLS), 12'd3);
		for (int i = 0; i < FILL_COLS * 3; i++)
			send_random(PIX_UNIFORM, i == 0);
		drain_results();
	endtask

	// Random sizes, mostly whole frames with random content, some broken frames.
	// Every line store entry these widths reach is written by now, so a size change
	// may land mid-frame.
	task automatic test_random_frames();
		int               sent, pick, w_eff, h_eff, n_frames, len;
		bit               broken;
		logic             fs;
		logic [SIZE_W-1:0] wv, hv;
		pix_style_t       style;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			wv = SIZE_W'((pick < 6) ? $urandom_range(3, 10) :
				(pick < 8) ? $urandom_range(11, FILL_COLS) : $urandom_range(0, 2));
			pick = $urandom_range(0, 9);
			hv = SIZE_W'((pick < 7) ? $urandom_range(3, 8) :
				(pick < 9) ? $urandom_range(9, 16) : $urandom_range(0, 2));
			set_frame_size(wv, hv);
			pick = $urandom_range(0, 9);
			idle_level = (pick < 1) ? IDLE_NONE : (pick < 4) ? IDLE_SHORT : IDLE_FULL;
			w_eff = clamp_size(wv, MAX_COLS);
			h_eff = clamp_size(hv, int'(HEIGHT_MAX));
			n_frames = $urandom_range(1, 3);
			for (int f = 0; f < n_frames; f++) begin
				style  = pix_style_t'($urandom_range(0, 3));
				broken = ($urandom_range(0, 9) >= 7);
				len = broken ? $urandom_range(1, w_eff * h_eff) : w_eff * h_eff;
				for (int i = 0; i < len; i++) begin
					if (i == 0)
						fs = (f == 0) ? ($urandom_range(0, 9) < 7) :
							($urandom_range(0, 1) == 1);
					else
						fs = broken && ($urandom_range(0, 15) == 0);
					send_random(style, fs);
					sent++;
				end
			end
		end
		drain_results();
	endtask

	// Test sequence and final verdict.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed();
		test_output_hold();
		test_size_extremes();
		test_random_frames();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && expected_edges.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/gse_pkg.sv
sv/gse_pos.sv
sv/gse_line_mem.sv
sv/gse_grad.sv
sv/gray_sobel_edge_stream.sv
test/gray_sobel_edge_stream_tb.sv
